FILE: sv/sfc_pkg.sv
package sfc_pkg;

	localparam int NUM_MOTORS_DEF = 64;
	localparam int MOTOR_W = 6;
	localparam int CMD_W = 3;
	localparam int WORD_W = 64;
	localparam int WIDX_W = 2;
	localparam int STORE_BITS = 192;
	localparam int FRAME_CNT_W = 3;
	localparam logic [WORD_W-1:0] MASK_RESET = 64'hFFFF_FFFF_FFFF_0000;

	// Frame kind, one bit per planned frame; the plan is shifted out MSB first.
	localparam logic KIND_FULL = 1'b0;
	localparam logic KIND_NOCLK = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_STORE = 3'd0,
		CMD_CLR_ONE = 3'd1,
		CMD_CLR_ALL = 3'd2,
		CMD_SEND = 3'd3,
		CMD_SEND_AUTO = 3'd4,
		CMD_SEND_CHG = 3'd5,
		CMD_SEND_CHG_AUTO = 3'd6
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic store;
		logic clr_one;
		logic clr_all;
		logic sent_full;
		logic sent_noclk;
		logic sel_noclk;
		logic [WIDX_W-1:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic rise;
		logic changed;
	} dp_sts_t;

endpackage

FILE: sv/sfc_cmd_if.sv
interface sfc_cmd_if;
	import sfc_pkg::*;

	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [MOTOR_W-1:0] motor_index;
	logic clk_bit;
	logic dir_bit;
	logic stby_bit;

	modport source(output valid, command, motor_index, clk_bit, dir_bit, stby_bit,
		input ready);
	modport sink(input valid, command, motor_index, clk_bit, dir_bit, stby_bit,
		output ready);
endinterface

FILE: sv/sfc_frame_if.sv
interface sfc_frame_if;
	import sfc_pkg::*;

	logic valid;
	logic ready;
	logic [WORD_W-1:0] frame_word;
	logic [WIDX_W-1:0] word_index;
	logic end_of_frame;
	logic last;

	modport source(output valid, frame_word, word_index, end_of_frame, last, input ready);
	modport sink(input valid, frame_word, word_index, end_of_frame, last, output ready);
endinterface

FILE: sv/sfc_cfg_if.sv
interface sfc_cfg_if;
	import sfc_pkg::*;

	logic valid;
	logic ready;
	logic [WORD_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: sv/sfc_datapath.sv
module sfc_datapath #(
	parameter int NUM_MOTORS = sfc_pkg::NUM_MOTORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfc_pkg::dp_cmd_t              ctl,
	output sfc_pkg::dp_sts_t              sts,
	input  logic [sfc_pkg::MOTOR_W-1:0]   motor,
	input  logic                          clk_bit,
	input  logic                          dir_bit,
	input  logic                          stby_bit,
	input  logic                          cfg_we,
	input  logic [sfc_pkg::WORD_W-1:0]    cfg_data,
	output logic [sfc_pkg::WORD_W-1:0]    frame_word
);
	import sfc_pkg::*;

	function automatic logic [STORE_BITS-1:0] build_mask(int offset);
		logic [STORE_BITS-1:0] m;
		m = '0;
		for (int k = 0; k < NUM_MOTORS; k++)
			m[STORE_BITS-1-(3*k+offset)] = 1'b1;
		return m;
	endfunction

	// Stream bit p sits at vector index STORE_BITS-1-p, so byte 0 is the top byte.
	localparam logic [STORE_BITS-1:0] CLK_MASK = build_mask(0);
	localparam logic [STORE_BITS-1:0] STBY_MASK = build_mask(2);

	logic [STORE_BITS-1:0] pending_q;
	logic [STORE_BITS-1:0] sent_q;
	logic [WORD_W-1:0]     mask_q;
	logic [STORE_BITS-1:0] pend_d;
	logic [STORE_BITS-1:0] noclk;
	logic [STORE_BITS-1:0] src;
	logic                  dir_eff;

	assign noclk = pending_q & ~CLK_MASK;
	assign dir_eff = dir_bit ^ mask_q[motor];

	assign sts.rise = |(pending_q & ~sent_q & STBY_MASK);
	assign sts.changed = (pending_q != sent_q);

	always_comb begin
		pend_d = pending_q;
		if (ctl.clr_all) begin
			pend_d = pending_q & ~(CLK_MASK | STBY_MASK);
		end
		for (int k = 0; k < NUM_MOTORS; k++) begin
			if (motor == MOTOR_W'(k)) begin
				if (ctl.store) begin
					pend_d[STORE_BITS-1-3*k] = clk_bit;
					pend_d[STORE_BITS-2-3*k] = dir_eff;
					pend_d[STORE_BITS-3-3*k] = stby_bit;
				end
				if (ctl.clr_one) begin
					pend_d[STORE_BITS-1-3*k] = 1'b0;
					pend_d[STORE_BITS-3-3*k] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			sent_q <= '0;
			mask_q <= MASK_RESET;
		end else begin
			pending_q <= pend_d;
			if (ctl.sent_full) begin
				sent_q <= pending_q;
			end else if (ctl.sent_noclk) begin
				sent_q <= noclk;
			end
			if (cfg_we) begin
				mask_q <= cfg_data;
			end
		end
	end

	assign src = ctl.sel_noclk ? noclk : pending_q;

	always_comb begin
		case (ctl.word_idx)
			2'd0: frame_word = src[STORE_BITS-1 -: WORD_W];
			2'd1: frame_word = src[STORE_BITS-1-WORD_W -: WORD_W];
			default: frame_word = src[WORD_W-1:0];
		endcase
	end
endmodule

FILE: sv/sfc_ctrl.sv
module sfc_ctrl #(
	parameter int NUM_MOTORS = sfc_pkg::NUM_MOTORS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sfc_pkg::CMD_W-1:0]   in_command,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sfc_pkg::WIDX_W-1:0]  out_word_index,
	output logic                        out_end_of_frame,
	output logic                        out_last,
	output sfc_pkg::dp_cmd_t            ctl,
	input  sfc_pkg::dp_sts_t            sts
);
	import sfc_pkg::*;

	localparam int FRAME_BYTES = (3 * NUM_MOTORS + 7) / 8;
	localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(FRAME_WORDS - 1);

	state_t                 state_q;
	state_t                 state_d;
	logic [3:0]             kinds_q;
	logic [FRAME_CNT_W-1:0] frames_q;
	logic [WIDX_W-1:0]      word_q;
	logic                   accept;
	logic                   out_acc;
	logic                   go;
	logic [3:0]             plan_kinds;
	logic [FRAME_CNT_W-1:0] plan_frames;
	logic                   plan_full;
	logic                   plan_noclk;

	assign accept = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Frame plan for a send, decided from the frames as they stand at acceptance.
	always_comb begin
		go = 1'b0;
		plan_kinds = {KIND_FULL, KIND_FULL, KIND_FULL, KIND_FULL};
		plan_frames = FRAME_CNT_W'(1);
		plan_full = 1'b0;
		plan_noclk = 1'b0;
		case (in_command)
			CMD_SEND, CMD_SEND_CHG: begin
				go = (in_command == CMD_SEND) || sts.changed;
				plan_full = go;
			end
			CMD_SEND_AUTO, CMD_SEND_CHG_AUTO: begin
				go = (in_command == CMD_SEND_AUTO) || sts.changed;
				plan_noclk = go;
				if (!sts.rise) begin
					plan_kinds = {KIND_FULL, KIND_NOCLK, KIND_FULL, KIND_FULL};
					plan_frames = FRAME_CNT_W'(2);
				end else if (in_command == CMD_SEND_AUTO) begin
					plan_kinds = {KIND_NOCLK, KIND_FULL, KIND_FULL, KIND_NOCLK};
					plan_frames = FRAME_CNT_W'(4);
				end else begin
					plan_kinds = {KIND_NOCLK, KIND_FULL, KIND_NOCLK, KIND_FULL};
					plan_frames = FRAME_CNT_W'(3);
				end
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && go) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && out_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		out_word_index = word_q;
		out_end_of_frame = (word_q == LAST_WORD);
		out_last = out_end_of_frame && (frames_q == FRAME_CNT_W'(1));
		ctl.store = accept && (in_command == CMD_STORE);
		ctl.clr_one = accept && (in_command == CMD_CLR_ONE);
		ctl.clr_all = accept && (in_command == CMD_CLR_ALL);
		ctl.sent_full = accept && plan_full;
		ctl.sent_noclk = accept && plan_noclk;
		ctl.sel_noclk = (kinds_q[3] == KIND_NOCLK);
		ctl.word_idx = word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kinds_q <= '0;
			frames_q <= '0;
			word_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				kinds_q <= plan_kinds;
				frames_q <= plan_frames;
				word_q <= '0;
			end else if (out_acc) begin
				if (out_end_of_frame) begin
					word_q <= '0;
					kinds_q <= {kinds_q[2:0], KIND_FULL};
					frames_q <= frames_q - FRAME_CNT_W'(1);
				end else begin
					word_q <= word_q + WIDX_W'(1);
				end
			end
		end
	end
endmodule

FILE: sv/stepper_shift_frame_composer.sv
// Stepper shift-register frame composer.
// The cmd channel takes one request at a time: stores and clears of a
// motor's clock, direction and standby bits, and send requests. The frame
// channel carries the frame as 64-bit words, first byte in the top bits,
// with word_index, end_of_frame and last. The cfg channel writes the
// direction invert mask; it is always ready, and the user must write it
// only while idle: the block itself does not enforce this. After a store or
// clear request cmd ready stays high. A send request with frames to send
// produces its first word on the cycle after acceptance and one word per
// cycle while the receiver is ready, F frames (0 to 4) of W words (3 at 64
// motors). The word sequencer in the controller steps the words; cmd ready
// stays low until the final word of the request is taken. When the receiver
// stalls, the current word and its tags are held unchanged. Reset clears both
// stored frames and loads the invert mask with 0xFFFF_FFFF_FFFF_0000.
module stepper_shift_frame_composer #(
	parameter int NUM_MOTORS = sfc_pkg::NUM_MOTORS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	sfc_cmd_if.sink      cmd,
	sfc_frame_if.source  frame,
	sfc_cfg_if.sink      cfg
);
	import sfc_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	sfc_ctrl #(.NUM_MOTORS(NUM_MOTORS)) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (cmd.valid),
		.in_ready         (cmd.ready),
		.in_command       (cmd.command),
		.out_valid        (frame.valid),
		.out_ready        (frame.ready),
		.out_word_index   (frame.word_index),
		.out_end_of_frame (frame.end_of_frame),
		.out_last         (frame.last),
		.ctl              (ctl),
		.sts              (sts)
	);

	sfc_datapath #(.NUM_MOTORS(NUM_MOTORS)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.motor      (cmd.motor_index),
		.clk_bit    (cmd.clk_bit),
		.dir_bit    (cmd.dir_bit),
		.stby_bit   (cmd.stby_bit),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data),
		.frame_word (frame.frame_word)
	);
endmodule

FILE: sv/sfc_checker.sv
module sfc_checker #(
	parameter int NUM_MOTORS = sfc_pkg::NUM_MOTORS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sfc_pkg::WORD_W-1:0]  out_frame_word,
	input logic [sfc_pkg::WIDX_W-1:0]  out_word_index,
	input logic                        out_end_of_frame,
	input logic                        out_last
);
	import sfc_pkg::*;

	localparam int FRAME_BYTES = (3 * NUM_MOTORS + 7) / 8;
	localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(FRAME_WORDS - 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_frame_word)
			&& $stable(out_word_index) && $stable(out_last))
		else $error("frame word changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while words are still going out");

	a_eof_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end_of_frame |-> out_word_index == LAST_WORD)
		else $error("end of frame on a wrong word position");

	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_end_of_frame |=>
			out_valid && out_word_index == $past(out_word_index) + 2'd1)
		else $error("words of a frame not in sequence");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("word delivered after the final word of a request");
endmodule

bind stepper_shift_frame_composer sfc_checker #(.NUM_MOTORS(NUM_MOTORS)) u_sfc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (cmd.ready),
	.out_valid        (frame.valid),
	.out_ready        (frame.ready),
	.out_frame_word   (frame.frame_word),
	.out_word_index   (frame.word_index),
	.out_end_of_frame (frame.end_of_frame),
	.out_last         (frame.last)
);

FILE: dv/stepper_shift_frame_composer_tb.sv
`timescale 1ns / 100ps

module stepper_shift_frame_composer_tb;
	import sfc_pkg::*;

	localparam int MOTORS = NUM_MOTORS_DEF;
	localparam int FRAME_BYTES = (3 * MOTORS + 7) / 8;
	localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
	localparam int MAX_WORDS = 12;
	localparam int MAX_FRAMES = 4;
	localparam int PREDICTED = -1;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef logic [STORE_BITS-1:0] frame_t;

	localparam frame_t FRAME_ZERO = '0;
	localparam frame_t FRAME_M0_CLK = frame_t'(8'h80) << (STORE_BITS - 8);
	localparam frame_t FRAME_M0_ALL = frame_t'(8'hE0) << (STORE_BITS - 8);
	localparam frame_t FRAME_M0_M63 = FRAME_M0_ALL | frame_t'(8'h07);

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [WIDX_W-1:0] idx;
		logic eof;
		logic last;
	} frame_word_t;

	typedef struct {
		logic [CMD_W-1:0] code;
		logic [MOTOR_W-1:0] motor;
		logic c;
		logic d;
		logic s;
		int typed_frames;
		frame_t typed;
	} row_t;

	// Typed rows give the frame count and the frame every emitted frame must equal.
	row_t plan [24] = '{
		'{CMD_SEND, 6'd0, 1'b0, 1'b0, 1'b0, 1, FRAME_ZERO},
		'{CMD_SEND_CHG, 6'd0, 1'b0, 1'b0, 1'b0, 0, FRAME_ZERO},
		'{CMD_SEND_CHG_AUTO, 6'd0, 1'b0, 1'b0, 1'b0, 0, FRAME_ZERO},
		'{CMD_STORE, 6'd0, 1'b1, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_SEND, 6'd0, 1'b0, 1'b0, 1'b0, 1, FRAME_M0_CLK},
		'{CMD_STORE, 6'd0, 1'b1, 1'b1, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND, 6'd0, 1'b0, 1'b0, 1'b0, 1, FRAME_M0_ALL},
		'{CMD_STORE, 6'd63, 1'b1, 1'b0, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND, 6'd63, 1'b1, 1'b1, 1'b1, 1, FRAME_M0_M63},
		'{CMD_SEND_CHG, 6'd0, 1'b0, 1'b0, 1'b0, 0, FRAME_ZERO},
		'{CMD_CLR_ONE, 6'd0, 1'b1, 1'b1, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_CHG, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_STORE, 6'd5, 1'b1, 1'b1, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_AUTO, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_AUTO, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_STORE, 6'd20, 1'b0, 1'b1, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_CHG_AUTO, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_CHG_AUTO, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_CLR_ALL, 6'd63, 1'b1, 1'b1, 1'b1, PREDICTED, FRAME_ZERO},
		'{CMD_SEND_CHG, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_UNUSED, 6'd63, 1'b1, 1'b1, 1'b1, 0, FRAME_ZERO},
		'{CMD_STORE, 6'd31, 1'b1, 1'b1, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_CLR_ONE, 6'd31, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO},
		'{CMD_SEND, 6'd0, 1'b0, 1'b0, 1'b0, PREDICTED, FRAME_ZERO}
	};

	logic clk = 1'b0;
	logic arst_n;

	sfc_cmd_if cmd_ch();
	sfc_frame_if frame_ch();
	sfc_cfg_if cfg_ch();

	stepper_shift_frame_composer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.frame(frame_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Own copy of the block's state.
	frame_t comp_frame;
	frame_t latched_frame;
	logic [WORD_W-1:0] inv_mask;
	frame_t clk_lane;
	frame_t stby_lane;

	frame_word_t words_due[$];
	int fail_cnt = 0;
	int burst_left = 0;
	frame_word_t seen_word;
	frame_word_t due_word;

	function automatic int lane_pos(int m, int off);
		return STORE_BITS - 1 - (3 * m + off);
	endfunction

	function automatic frame_t lane_mask(int off);
		frame_t r;
		r = '0;
		for (int m = 0; m < MOTORS; m++)
			r[lane_pos(m, off)] = 1'b1;
		return r;
	endfunction

	task automatic note_failure(string what, frame_word_t due, frame_word_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t %s: expected %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime, what,
				due.data, due.idx, due.eof, due.last, got.data, got.idx, got.eof, got.last);
	endtask

	// Applies one request to the state and lists the frames it puts on the wire.
	task automatic apply_request(input logic [CMD_W-1:0] code, input logic [MOTOR_W-1:0] motor,
		input logic c, input logic d, input logic s, output frame_t frames [MAX_FRAMES],
		output int nf);
		frame_t noclk;
		logic rise;
		logic changed;
		noclk = comp_frame & ~clk_lane;
		rise = |(comp_frame & ~latched_frame & stby_lane);
		changed = comp_frame != latched_frame;
		nf = 0;
		for (int k = 0; k < MAX_FRAMES; k++)
			frames[k] = '0;
		case (code)
			CMD_STORE: begin
				if (motor < MOTORS) begin
					comp_frame[lane_pos(motor, 0)] = c;
					comp_frame[lane_pos(motor, 1)] = d ^ inv_mask[motor];
					comp_frame[lane_pos(motor, 2)] = s;
				end
			end
			CMD_CLR_ONE: begin
				if (motor < MOTORS) begin
					comp_frame[lane_pos(motor, 0)] = 1'b0;
					comp_frame[lane_pos(motor, 2)] = 1'b0;
				end
			end
			CMD_CLR_ALL: comp_frame = comp_frame & ~(clk_lane | stby_lane);
			CMD_SEND, CMD_SEND_CHG: begin
				if (code == CMD_SEND || changed) begin
					frames[0] = comp_frame;
					nf = 1;
					latched_frame = comp_frame;
				end
			end
			CMD_SEND_AUTO, CMD_SEND_CHG_AUTO: begin
				if (code == CMD_SEND_AUTO || changed) begin
					if (rise) begin
						frames[nf] = noclk;
						nf++;
						if (code == CMD_SEND_AUTO) begin
							frames[nf] = comp_frame;
							nf++;
						end
					end
					frames[nf] = comp_frame;
					nf++;
					frames[nf] = noclk;
					nf++;
					latched_frame = noclk;
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_frames(input frame_t frames [MAX_FRAMES], input int nf);
		frame_word_t w;
		int total;
		int n;
		total = (nf * FRAME_WORDS > MAX_WORDS) ? MAX_WORDS : nf * FRAME_WORDS;
		n = 0;
		for (int k = 0; k < nf; k++) begin
			for (int i = 0; i < FRAME_WORDS; i++) begin
				if (n < total) begin
					w.data = frames[k][STORE_BITS - 1 - WORD_W * i -: WORD_W];
					w.idx = WIDX_W'(i);
					w.eof = (i == FRAME_WORDS - 1);
					w.last = (n == total - 1);
					words_due.push_back(w);
					n++;
				end
			end
		end
	endtask

	// Sender works in bursts; a gap drops valid for a random number of cycles.
	task automatic send_request(input logic [CMD_W-1:0] code, input logic [MOTOR_W-1:0] motor,
		input logic c, input logic d, input logic s, input int typed_frames, input frame_t typed);
		frame_t frames [MAX_FRAMES];
		int nf;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		cmd_ch.valid = 1'b1;
		cmd_ch.command = code;
		cmd_ch.motor_index = motor;
		cmd_ch.clk_bit = c;
		cmd_ch.dir_bit = d;
		cmd_ch.stby_bit = s;
		do @(posedge clk); while (!cmd_ch.ready);
		burst_left--;
		apply_request(code, motor, c, d, s, frames, nf);
		if (typed_frames != PREDICTED) begin
			nf = typed_frames;
			for (int k = 0; k < MAX_FRAMES; k++)
				frames[k] = typed;
		end
		queue_frames(frames, nf);
	endtask

	// Stores and clears give no words, so the bench lets the block settle once
	// the last due word has arrived.
	task automatic wait_idle();
		int spins;
		frame_word_t none;
		none = '0;
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		spins = 0;
		while (words_due.size() != 0 && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		while (words_due.size() != 0)
			note_failure("word never produced", words_due.pop_front(), none);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [WORD_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		inv_mask = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic random_request();
		int pick;
		logic [CMD_W-1:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			code = CMD_STORE;
		else if (pick < 50)
			code = CMD_CLR_ONE;
		else if (pick < 54)
			code = CMD_CLR_ALL;
		else if (pick < 64)
			code = CMD_SEND;
		else if (pick < 74)
			code = CMD_SEND_AUTO;
		else if (pick < 86)
			code = CMD_SEND_CHG;
		else if (pick < 98)
			code = CMD_SEND_CHG_AUTO;
		else
			code = CMD_UNUSED;
		send_request(code, MOTOR_W'($urandom_range(0, MOTORS - 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), PREDICTED, FRAME_ZERO);
	endtask

	// Receiver stall pattern is redrawn whenever its random run ends.
	int stall_mode = 0;
	int stall_left = 0;
	int tick = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 60);
		end
		stall_left--;
		tick++;
		case (stall_mode)
			0: frame_ch.ready = 1'b1;
			1: frame_ch.ready = 1'($urandom_range(0, 1));
			2: frame_ch.ready = (tick % 4 == 0);
			default: frame_ch.ready = (tick % 8 < 5);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			seen_word.data = frame_ch.frame_word;
			seen_word.idx = frame_ch.word_index;
			seen_word.eof = frame_ch.end_of_frame;
			seen_word.last = frame_ch.last;
			if (words_due.size() == 0) begin
				note_failure("unexpected word", '0, seen_word);
			end else begin
				due_word = words_due.pop_front();
				if (due_word != seen_word)
					note_failure("word mismatch", due_word, seen_word);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [WORD_W-1:0] masks [5];
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_STORE;
		cmd_ch.motor_index = '0;
		cmd_ch.clk_bit = 1'b0;
		cmd_ch.dir_bit = 1'b0;
		cmd_ch.stby_bit = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		frame_ch.ready = 1'b0;
		clk_lane = lane_mask(0);
		stby_lane = lane_mask(2);
		comp_frame = '0;
		latched_frame = '0;
		inv_mask = MASK_RESET;
		masks[0] = '1;
		masks[1] = '0;
		masks[2] = 64'hAAAA_AAAA_AAAA_AAAA;
		masks[3] = {$urandom, $urandom};
		masks[4] = {$urandom, $urandom};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows run under the reset value of the invert mask.
		foreach (plan[i])
			send_request(plan[i].code, plan[i].motor, plan[i].c, plan[i].d, plan[i].s,
				plan[i].typed_frames, plan[i].typed);

		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_mask(masks[p]);
			repeat (92) random_request();
		end

		wait_idle();
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
